// File: hdl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg: shared types and constants of the ready queue scheduler.
// Holds the call codes, the status codes and the default sizes.
// ----------------------------------------------------------------------------
package prq_pkg;
  localparam int DefThreads = 8;
  localparam int DefLevels  = 16;

  localparam logic [3:0] K_YIELD   = 4'd0;
  localparam logic [3:0] K_SLEEP   = 4'd1;
  localparam logic [3:0] K_WAKEUP  = 4'd2;
  localparam logic [3:0] K_CHGPRI  = 4'd3;
  localparam logic [3:0] K_CREATE  = 4'd4;
  localparam logic [3:0] K_EXIT    = 4'd5;
  localparam logic [3:0] K_GETID   = 4'd6;
  localparam logic [3:0] K_SVCWAKE = 4'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSLOT = 2'd1;
  localparam logic [1:0] ST_HALT   = 2'd2;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] target_thread;
    logic [3:0] priority_req;
    logic       keep_priority;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] dispatch_thread;
    logic [3:0] return_value;
  } rsp_t;
endpackage

// File: hdl/prq_if.sv
// ----------------------------------------------------------------------------
// prq_if: valid/ready channel carrying one payload.
// A request moves on a clock edge at which valid and ready are both high.
// ----------------------------------------------------------------------------
interface prq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/prq_engine.sv
// ----------------------------------------------------------------------------
// prq_engine: scheduler sequencer around the level pointer memory.
// Runs one call as a sequence of memory reads and writes, then a level scan.
// ----------------------------------------------------------------------------
module prq_engine import prq_pkg::*; #(
  parameter int THREADS = DefThreads,
  parameter int LEVELS  = DefLevels
) (
  input  logic clk,
  input  logic rst,
  prq_if.sink   req,
  prq_if.source rsp
);
  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RM_RD, S_RM_WR, S_APPLY, S_EQ_START, S_EQ_RD, S_EQ_WR, S_SCAN,
    S_SCAN_RD, S_OUT
  } state_t;

  // Level memory: head and tail pointers, one synchronous read port.
  logic [2*TW-1:0] lvl_mem [LEVELS];
  logic [2*TW-1:0] lvl_rd;
  logic [LW-1:0]   lvl_raddr;
  logic            lvl_we;
  logic [LW-1:0]   lvl_waddr;
  logic [2*TW-1:0] lvl_wdata;
  logic [LEVELS-1:0] lvl_nonempty;

  logic [TW-1:0] next_link [THREADS];
  logic [THREADS-1:0] link_ok;
  logic [LW-1:0] thread_level [THREADS];
  logic [THREADS-1:0] ready_flag;
  logic [THREADS-1:0] slot_used;
  logic [TW-1:0] running_thread;
  logic running_ok;
  logic halted;

  state_t state;
  req_t   cur;
  rsp_t   out;
  logic   out_valid;
  logic [1:0] eq_step;
  logic [TW-1:0] eq_t;
  logic [3:0] rv;
  logic [1:0] st;
  logic [TW-1:0] new_idx;
  logic          new_ok;

  logic [LW-1:0] req_level;
  logic [TW-1:0] free_idx;
  logic          free_found;
  logic [LW-1:0] first_lvl;
  logic          any_lvl;
  logic          tgt_ok;

  always_comb begin
    req_level = (32'(cur.priority_req) >= 32'(LEVELS)) ? LW'(LEVELS - 1)
                                                       : LW'(cur.priority_req);
    free_idx = '0;
    free_found = 1'b0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx = TW'(i);
        free_found = 1'b1;
      end
    end
    first_lvl = '0;
    any_lvl = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (lvl_nonempty[i]) begin
        first_lvl = LW'(i);
        any_lvl = 1'b1;
      end
    end
    tgt_ok = (32'(cur.target_thread) < 32'(THREADS)) &&
             slot_used[TW'(cur.target_thread)];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
    lvl_rd <= lvl_mem[lvl_raddr];
  end

  // Picks the enqueue candidate for step n of the current call.
  function automatic logic [TW:0] eq_pick(input logic [1:0] n, input req_t c,
      input logic run_ok, input logic [TW-1:0] run_t, input logic t_ok,
      input logic f_ok, input logic [TW-1:0] f_idx);
    logic [TW:0] r;
    r = '0;
    if (n == 2'd0) begin
      if (run_ok && (c.kind == K_YIELD || c.kind == K_WAKEUP ||
                     c.kind == K_CHGPRI || c.kind == K_CREATE ||
                     c.kind == K_GETID))
        r = {1'b1, run_t};
      else if (c.kind == K_SVCWAKE && t_ok)
        r = {1'b1, TW'(c.target_thread)};
    end else if (n == 2'd1) begin
      if (c.kind == K_WAKEUP && t_ok) r = {1'b1, TW'(c.target_thread)};
      else if (c.kind == K_CREATE && f_ok) r = {1'b1, f_idx};
    end
    return r;
  endfunction

  logic [TW:0] pick;
  assign pick = eq_pick(eq_step, cur, running_ok, running_thread, tgt_ok,
                        new_ok, new_idx);

  always_comb begin
    lvl_raddr = thread_level[running_thread];
    if (state == S_EQ_RD) lvl_raddr = thread_level[eq_t];
    if (state == S_SCAN) lvl_raddr = first_lvl;
    lvl_we = 1'b0;
    lvl_waddr = lvl_raddr;
    lvl_wdata = lvl_rd;
    if (state == S_RM_WR) begin
      lvl_we = link_ok[lvl_rd[2*TW-1:TW]];
      lvl_waddr = thread_level[running_thread];
      lvl_wdata = {next_link[lvl_rd[2*TW-1:TW]], lvl_rd[TW-1:0]};
    end else if (state == S_EQ_WR) begin
      lvl_we = 1'b1;
      lvl_waddr = thread_level[eq_t];
      lvl_wdata = lvl_nonempty[thread_level[eq_t]] ? {lvl_rd[2*TW-1:TW], eq_t}
                                                   : {eq_t, eq_t};
    end
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      link_ok <= '0;
      ready_flag <= '0;
      slot_used <= '0;
      running_ok <= 1'b0;
      running_thread <= '0;
      halted <= 1'b0;
      lvl_nonempty <= '0;
      for (int i = 0; i < THREADS; i++) begin
        thread_level[i] <= '0;
        next_link[i] <= '0;
      end
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            cur <= req.data;
            rv <= '0;
            st <= ST_OK;
            eq_step <= '0;
            if (halted) begin
              out <= '{status: ST_HALT, dispatch_thread: '0, return_value: '0};
              out_valid <= 1'b1;
            end else if (req.data.kind <= K_GETID && running_ok &&
                         ready_flag[running_thread]) begin
              state <= S_RM_RD;
            end else begin
              state <= S_APPLY;
            end
          end
        end
        S_RM_RD: state <= S_RM_WR;
        S_RM_WR: begin
          if (lvl_nonempty[thread_level[running_thread]]) begin
            if (!link_ok[lvl_rd[2*TW-1:TW]])
              lvl_nonempty[thread_level[running_thread]] <= 1'b0;
            link_ok[lvl_rd[2*TW-1:TW]] <= 1'b0;
          end
          ready_flag[running_thread] <= 1'b0;
          state <= S_APPLY;
        end
        S_APPLY: begin
          new_idx <= free_idx;
          new_ok <= free_found;
          case (cur.kind)
            K_CHGPRI: if (running_ok) begin
              rv <= 4'(thread_level[running_thread]);
              if (!cur.keep_priority) thread_level[running_thread] <= req_level;
            end
            K_CREATE: if (free_found) begin
              rv <= 4'(free_idx);
              slot_used[free_idx] <= 1'b1;
              thread_level[free_idx] <= req_level;
              ready_flag[free_idx] <= 1'b0;
              link_ok[free_idx] <= 1'b0;
              next_link[free_idx] <= '0;
            end else st <= ST_NOSLOT;
            K_EXIT: if (running_ok) begin
              slot_used[running_thread] <= 1'b0;
              thread_level[running_thread] <= '0;
              ready_flag[running_thread] <= 1'b0;
              link_ok[running_thread] <= 1'b0;
              next_link[running_thread] <= '0;
              running_ok <= 1'b0;
              running_thread <= '0;
            end
            K_GETID: if (running_ok) rv <= 4'(running_thread);
            default: ;
          endcase
          state <= S_EQ_START;
        end
        S_EQ_START: begin
          if (eq_step == 2'd2) begin
            state <= S_SCAN;
          end else begin
            eq_step <= eq_step + 2'd1;
            if (pick[TW] && !ready_flag[pick[TW-1:0]]) begin
              eq_t <= pick[TW-1:0];
              state <= S_EQ_RD;
            end
          end
        end
        S_EQ_RD: state <= S_EQ_WR;
        S_EQ_WR: begin
          if (lvl_nonempty[thread_level[eq_t]]) begin
            next_link[lvl_rd[TW-1:0]] <= eq_t;
            link_ok[lvl_rd[TW-1:0]] <= 1'b1;
          end
          lvl_nonempty[thread_level[eq_t]] <= 1'b1;
          link_ok[eq_t] <= 1'b0;
          ready_flag[eq_t] <= 1'b1;
          state <= S_EQ_START;
        end
        S_SCAN: begin
          if (!any_lvl) begin
            halted <= 1'b1;
            running_ok <= 1'b0;
            running_thread <= '0;
            out <= '{status: ST_HALT, dispatch_thread: '0, return_value: '0};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          running_thread <= lvl_rd[2*TW-1:TW];
          running_ok <= 1'b1;
          out <= '{status: st, dispatch_thread: 3'(lvl_rd[2*TW-1:TW]),
                   return_value: rv};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/priority_ready_queue_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_ready_queue_scheduler_top: hardware thread scheduler.
// Steps of a request on the level pointer memory port: removal, call update,
// up to two enqueues and the dispatch read. When no thread is left the halt is
// raised; once halted, requests get halt status. One request in flight.
// Synchronous reset empties all queues, frees all slots and clears the halt.
// ----------------------------------------------------------------------------
module priority_ready_queue_scheduler_top import prq_pkg::*; #(
  parameter int THREADS = DefThreads,
  parameter int LEVELS  = DefLevels
) (
  input logic clk,
  input logic rst,
  prq_if.sink   req,
  prq_if.source rsp
);
  prq_engine #(.THREADS(THREADS), .LEVELS(LEVELS)) u_engine (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp)
  );

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    u_engine.halted |=> u_engine.halted) else $error("halt cleared");
  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && u_engine.halted) |-> rsp.data.status == ST_HALT)
    else $error("halt status");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("accept while busy");
endmodule
